### rtl/core/tfs_pkg.sv
package tfs_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned ADDR_W      = 15;
    localparam int unsigned STORE_DEPTH = 32768;
    localparam int unsigned COORD_W     = 8;
    localparam int unsigned FRAC_W      = 17;
    localparam int unsigned NUM_CORNERS = 8;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned OUT_DEPTH   = 4;
    localparam int unsigned PADDR_W     = 5;

    localparam int unsigned GRID_X_DEF = 32;
    localparam int unsigned GRID_Y_DEF = 32;
    localparam int unsigned GRID_Z_DEF = 32;

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);
    localparam logic [DATA_W-1:0] INV_RESET = 32'h0001_0000;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_INV_X    = 3'd3;
    localparam logic [2:0] REG_INV_Y    = 3'd4;
    localparam logic [2:0] REG_INV_Z    = 3'd5;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // corner slot = z*4 + y*2 + x; a write uses slot 0 for its address
    typedef struct packed {
        t_op                                  op;
        logic                                 inb;
        logic [NUM_CORNERS-1:0][ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]                    data;
        logic [FRAC_W-1:0]                    tx;
        logic [FRAC_W-1:0]                    ty;
        logic [FRAC_W-1:0]                    tz;
    } t_qent;

    typedef struct packed {
        logic              inb;
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] gx;
        logic [DATA_W-1:0] gy;
        logic [DATA_W-1:0] gz;
    } t_res;

endpackage

### rtl/core/tfs_ram.sv
module tfs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/tfs_fifo.sv
module tfs_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

endmodule

### rtl/core/tfs_front.sv
module tfs_front #(
    parameter int unsigned GRID_X = tfs_pkg::GRID_X_DEF,
    parameter int unsigned GRID_Y = tfs_pkg::GRID_Y_DEF,
    parameter int unsigned GRID_Z = tfs_pkg::GRID_Z_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic                              i_operation,
    input  logic [tfs_pkg::ADDR_W-1:0]        i_sample_address,
    input  logic signed [tfs_pkg::DATA_W-1:0] i_sample_data,
    input  logic signed [tfs_pkg::DATA_W-1:0] i_point_x,
    input  logic signed [tfs_pkg::DATA_W-1:0] i_point_y,
    input  logic signed [tfs_pkg::DATA_W-1:0] i_point_z,
    input  logic signed [tfs_pkg::DATA_W-1:0] i_origin_x,
    input  logic signed [tfs_pkg::DATA_W-1:0] i_origin_y,
    input  logic signed [tfs_pkg::DATA_W-1:0] i_origin_z,
    input  logic [tfs_pkg::DATA_W-1:0]        i_inv_x,
    input  logic [tfs_pkg::DATA_W-1:0]        i_inv_y,
    input  logic [tfs_pkg::DATA_W-1:0]        i_inv_z,
    output tfs_pkg::t_qent                    o_entry,
    output logic                              o_entry_push,
    input  logic                              i_q_full
);

    import tfs_pkg::*;

    typedef struct packed {
        logic               out;
        logic [COORD_W-1:0] base;
        logic [FRAC_W-1:0]  t;
    } t_axis;

    localparam logic [31:0] LAST  [3] = '{32'(GRID_X - 1), 32'(GRID_Y - 1), 32'(GRID_Z - 1)};
    localparam logic [31:0] CLAMP [3] = '{32'(GRID_X - 2), 32'(GRID_Y - 2), 32'(GRID_Z - 2)};

    function automatic t_axis classify(input logic [63:0] prod, input logic neg,
                                       input logic [31:0] last, input logic [31:0] clamp);
        t_axis r;
        r.out = neg || (prod[63:32] > last) || ((prod[63:32] == last) && (prod[31:0] != '0));
        if (prod[63:32] > clamp) begin
            // only the top edge itself stays in bounds here
            r.base = clamp[COORD_W-1:0];
            r.t    = FRAC_ONE;
        end else begin
            r.base = prod[32 +: COORD_W];
            r.t    = {1'b0, prod[31:16]};
        end
        return r;
    endfunction

    logic signed [DATA_W-1:0] w_p   [3];
    logic signed [DATA_W-1:0] w_o   [3];
    logic [DATA_W-1:0]        w_inv [3];
    t_axis                    w_ax  [3];
    logic                     w_en;
    logic                     w_acc;
    t_qent                    n_entry;

    logic [4:0]               r_v;
    t_op                      r_op    [4];
    logic [ADDR_W-1:0]        r_waddr [4];
    logic [DATA_W-1:0]        r_wdata [4];

    logic signed [DATA_W:0]   r_d     [3];
    logic                     r_neg   [3];
    logic [63:0]              r_prod  [3];
    logic                     r2_out;
    logic [COORD_W-1:0]       r2_base [3];
    logic [FRAC_W-1:0]        r2_t    [3];
    logic [15:0]              r3_zy;
    logic [COORD_W-1:0]       r3_bx;
    logic [FRAC_W-1:0]        r3_t    [3];
    logic                     r3_inb;
    t_qent                    r_entry;

    assign w_p   = '{i_point_x, i_point_y, i_point_z};
    assign w_o   = '{i_origin_x, i_origin_y, i_origin_z};
    assign w_inv = '{i_inv_x, i_inv_y, i_inv_z};

    assign w_en         = !(r_v[4] && i_q_full);
    assign o_full       = !w_en;
    assign w_acc        = i_push && w_en;
    assign o_entry      = r_entry;
    assign o_entry_push = r_v[4];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_ax[a] = classify(r_prod[a], r_neg[a], LAST[a], CLAMP[a]);
        end
    end

    // corner addresses wrap at the store depth
    always_comb begin
        logic [15:0] row;
        logic [15:0] rowx;
        n_entry    = '0;
        n_entry.op = r_op[3];
        n_entry.inb = r3_inb;
        n_entry.data = r_wdata[3];
        n_entry.tx = r3_t[0];
        n_entry.ty = r3_t[1];
        n_entry.tz = r3_t[2];
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                row  = r3_zy + (i[0] ? 16'(GRID_Y) : 16'd0) + 16'(j);
                rowx = row * 16'(GRID_X);
                for (int l = 0; l < 2; l++) begin
                    n_entry.addr[i*4 + j*2 + l] = rowx[ADDR_W-1:0] + ADDR_W'(r3_bx)
                                                  + ADDR_W'(l);
                end
            end
        end
        if (r_op[3] == OP_WRITE) begin
            n_entry.addr[0] = r_waddr[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[3:0], w_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op[0]    <= t_op'(i_operation);
            r_waddr[0] <= i_sample_address;
            r_wdata[0] <= i_sample_data;
            for (int s = 1; s < 4; s++) begin
                r_op[s]    <= r_op[s-1];
                r_waddr[s] <= r_waddr[s-1];
                r_wdata[s] <= r_wdata[s-1];
            end
            for (int a = 0; a < 3; a++) begin
                r_d[a]     <= 33'(w_p[a]) - 33'(w_o[a]);
                r_neg[a]   <= r_d[a][DATA_W];
                r_prod[a]  <= 64'(r_d[a][DATA_W-1:0]) * 64'(w_inv[a]);
                r2_base[a] <= w_ax[a].base;
                r2_t[a]    <= w_ax[a].t;
                r3_t[a]    <= r2_t[a];
            end
            r2_out  <= w_ax[0].out || w_ax[1].out || w_ax[2].out;
            r3_zy   <= 16'(r2_base[2]) * 16'(GRID_Y) + 16'(r2_base[1]);
            r3_bx   <= r2_base[0];
            r3_inb  <= !r2_out;
            r_entry <= n_entry;
        end
    end

endmodule

### rtl/core/tfs_back.sv
module tfs_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tfs_pkg::t_qent             i_entry,
    input  logic                       i_q_empty,
    output logic                       o_q_pop,
    input  logic [tfs_pkg::DATA_W-1:0] i_inv_x,
    input  logic [tfs_pkg::DATA_W-1:0] i_inv_y,
    input  logic [tfs_pkg::DATA_W-1:0] i_inv_z,
    output tfs_pkg::t_res              o_res,
    output logic                       o_res_push,
    input  logic                       i_res_full
);

    import tfs_pkg::*;

    function automatic logic signed [32:0] sub33(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return 33'(a) - 33'(b);
    endfunction

    function automatic logic signed [51:0] mul_t(input logic signed [33:0] d,
                                                 input logic [16:0] t);
        logic signed [17:0] ts;
        ts = $signed({1'b0, t});
        return 52'(d) * 52'(ts);
    endfunction

    // a + floor(p / 65536)
    function automatic logic signed [51:0] lsum(input logic signed [32:0] a,
                                                input logic signed [51:0] p);
        return 52'(a) + (p >>> 16);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        if (v > 52'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -52'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    logic                     w_en;
    logic                     w_pop;
    logic                     w_we;
    logic [DATA_W-1:0]        w_k [NUM_CORNERS];

    logic [9:1]               r_v;
    logic                     r_inb [1:9];
    logic [FRAC_W-1:0]        r_tx  [1:9];
    logic [FRAC_W-1:0]        r_ty  [1:9];
    logic [FRAC_W-1:0]        r_tz  [1:9];

    logic signed [32:0]       r2_dx [4];
    logic signed [31:0]       r2_a  [4];
    logic signed [32:0]       r2_dy [4];
    logic signed [51:0]       r3_mx [4];
    logic signed [31:0]       r3_a  [4];
    logic signed [33:0]       r3_ddx [2];
    logic signed [32:0]       r3_dx0 [2];
    logic signed [33:0]       r3_ddy [2];
    logic signed [32:0]       r3_dy0 [2];
    logic signed [31:0]       r4_c  [4];
    logic signed [51:0]       r4_mgx [2];
    logic signed [32:0]       r4_dx0 [2];
    logic signed [51:0]       r4_mgy [2];
    logic signed [32:0]       r4_dy0 [2];
    logic signed [32:0]       r5_dc  [2];
    logic signed [31:0]       r5_c0  [2];
    logic signed [32:0]       r5_gxi [2];
    logic signed [32:0]       r5_gyi [2];
    logic signed [51:0]       r6_mc  [2];
    logic signed [31:0]       r6_c0  [2];
    logic signed [33:0]       r6_dgx;
    logic signed [32:0]       r6_gx0;
    logic signed [33:0]       r6_dgy;
    logic signed [32:0]       r6_gy0;
    logic signed [31:0]       r7_cz  [2];
    logic signed [51:0]       r7_mgx;
    logic signed [32:0]       r7_gx0;
    logic signed [51:0]       r7_mgy;
    logic signed [32:0]       r7_gy0;
    logic signed [32:0]       r8_dz;
    logic signed [31:0]       r8_cz0;
    logic signed [32:0]       r8_gx;
    logic signed [32:0]       r8_gy;
    logic signed [51:0]       r9_mz;
    logic signed [31:0]       r9_cz0;
    logic signed [51:0]       r9_gxh;
    logic signed [51:0]       r9_gxl;
    logic signed [51:0]       r9_gyh;
    logic signed [51:0]       r9_gyl;
    logic signed [51:0]       r9_gzh;
    logic signed [51:0]       r9_gzl;

    assign w_en       = !(r_v[9] && i_res_full);
    assign w_pop      = w_en && !i_q_empty;
    assign w_we       = w_pop && (i_entry.op == OP_WRITE);
    assign o_q_pop    = w_pop;
    assign o_res_push = r_v[9] && w_en;

    // one full copy of the store per corner so all eight reads go out together
    for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_bank
        tfs_ram #(
            .WIDTH (DATA_W),
            .DEPTH (STORE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (i_entry.addr[0]),
            .i_wdata (i_entry.data),
            .i_re    (w_en),
            .i_raddr (i_entry.addr[c]),
            .o_rdata (w_k[c])
        );
    end

    always_comb begin
        o_res = '0;
        if (r_inb[9]) begin
            o_res.inb = 1'b1;
            o_res.val = sat32(lsum(33'(r9_cz0), r9_mz));
            o_res.gx  = sat32(r9_gxh + (r9_gxl >>> 16));
            o_res.gy  = sat32(r9_gyh + (r9_gyl >>> 16));
            o_res.gz  = sat32(r9_gzh + (r9_gzl >>> 16));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[8:1], w_pop && (i_entry.op == OP_QUERY)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_inb[1] <= i_entry.inb;
            r_tx[1]  <= i_entry.tx;
            r_ty[1]  <= i_entry.ty;
            r_tz[1]  <= i_entry.tz;
            for (int s = 2; s <= 9; s++) begin
                r_inb[s] <= r_inb[s-1];
                r_tx[s]  <= r_tx[s-1];
                r_ty[s]  <= r_ty[s-1];
                r_tz[s]  <= r_tz[s-1];
            end

            // corner differences along x and y
            for (int i = 0; i < 2; i++) begin
                for (int j = 0; j < 2; j++) begin
                    r2_dx[i*2+j] <= sub33(w_k[i*4 + j*2 + 1], w_k[i*4 + j*2]);
                    r2_a[i*2+j]  <= w_k[i*4 + j*2];
                    r2_dy[i*2+j] <= sub33(w_k[i*4 + 2 + j], w_k[i*4 + j]);
                end
            end

            for (int q = 0; q < 4; q++) begin
                r3_mx[q] <= mul_t(34'(r2_dx[q]), r_tx[2]);
                r3_a[q]  <= r2_a[q];
                r4_c[q]  <= sat32(lsum(33'(r3_a[q]), r3_mx[q]));
            end

            for (int i = 0; i < 2; i++) begin
                r3_ddx[i] <= 34'(r2_dx[i*2+1]) - 34'(r2_dx[i*2]);
                r3_dx0[i] <= r2_dx[i*2];
                r3_ddy[i] <= 34'(r2_dy[i*2+1]) - 34'(r2_dy[i*2]);
                r3_dy0[i] <= r2_dy[i*2];

                r4_mgx[i] <= mul_t(r3_ddx[i], r_ty[3]);
                r4_dx0[i] <= r3_dx0[i];
                r4_mgy[i] <= mul_t(r3_ddy[i], r_tx[3]);
                r4_dy0[i] <= r3_dy0[i];

                r5_dc[i]  <= sub33(r4_c[i*2+1], r4_c[i*2]);
                r5_c0[i]  <= r4_c[i*2];
                r5_gxi[i] <= 33'(lsum(r4_dx0[i], r4_mgx[i]));
                r5_gyi[i] <= 33'(lsum(r4_dy0[i], r4_mgy[i]));

                r6_mc[i]  <= mul_t(34'(r5_dc[i]), r_ty[5]);
                r6_c0[i]  <= r5_c0[i];

                r7_cz[i]  <= sat32(lsum(33'(r6_c0[i]), r6_mc[i]));
            end

            r6_dgx <= 34'(r5_gxi[1]) - 34'(r5_gxi[0]);
            r6_gx0 <= r5_gxi[0];
            r6_dgy <= 34'(r5_gyi[1]) - 34'(r5_gyi[0]);
            r6_gy0 <= r5_gyi[0];

            r7_mgx <= mul_t(r6_dgx, r_tz[6]);
            r7_gx0 <= r6_gx0;
            r7_mgy <= mul_t(r6_dgy, r_tz[6]);
            r7_gy0 <= r6_gy0;

            r8_dz  <= sub33(r7_cz[1], r7_cz[0]);
            r8_cz0 <= r7_cz[0];
            r8_gx  <= 33'(lsum(r7_gx0, r7_mgx));
            r8_gy  <= 33'(lsum(r7_gy0, r7_mgy));

            // gradient scaling split into high and low halves of the inverse cell
            r9_mz  <= mul_t(34'(r8_dz), r_tz[8]);
            r9_cz0 <= r8_cz0;
            r9_gxh <= mul_t(34'(r8_gx), {1'b0, i_inv_x[31:16]});
            r9_gxl <= mul_t(34'(r8_gx), {1'b0, i_inv_x[15:0]});
            r9_gyh <= mul_t(34'(r8_gy), {1'b0, i_inv_y[31:16]});
            r9_gyl <= mul_t(34'(r8_gy), {1'b0, i_inv_y[15:0]});
            r9_gzh <= mul_t(34'(r8_dz), {1'b0, i_inv_z[31:16]});
            r9_gzl <= mul_t(34'(r8_dz), {1'b0, i_inv_z[15:0]});
        end
    end

endmodule

### rtl/core/trilinear_field_sampler_core.sv
// Throughput: one word per cycle on the input queue, writes and queries alike,
// while full is low. A query's result passes through 5 mapping stages, the item
// queue, a registered store read, 8 math stages and the result queue before it
// shows on the output queue.
// Reset (synchronous, active low) empties all queues and pipelines and loads the
// registers with origin 0 and inverse cell 1.0; grid contents are undefined until written.
module trilinear_field_sampler_core #(
    parameter int unsigned GRID_X = tfs_pkg::GRID_X_DEF,
    parameter int unsigned GRID_Y = tfs_pkg::GRID_Y_DEF,
    parameter int unsigned GRID_Z = tfs_pkg::GRID_Z_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tfs_pkg::PADDR_W-1:0]        paddr,
    input  logic [tfs_pkg::DATA_W-1:0]         pwdata,
    output logic [tfs_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  logic                               push,
    output logic                               full,
    input  logic                               i_operation,
    input  logic [tfs_pkg::ADDR_W-1:0]         i_sample_address,
    input  logic signed [tfs_pkg::DATA_W-1:0]  i_sample_data,
    input  logic signed [tfs_pkg::DATA_W-1:0]  i_point_x,
    input  logic signed [tfs_pkg::DATA_W-1:0]  i_point_y,
    input  logic signed [tfs_pkg::DATA_W-1:0]  i_point_z,
    output logic                               empty,
    input  logic                               pop,
    output logic                               o_in_bounds,
    output logic signed [tfs_pkg::DATA_W-1:0]  o_field_value,
    output logic signed [tfs_pkg::DATA_W-1:0]  o_gradient_x,
    output logic signed [tfs_pkg::DATA_W-1:0]  o_gradient_y,
    output logic signed [tfs_pkg::DATA_W-1:0]  o_gradient_z
);

    import tfs_pkg::*;

    logic signed [DATA_W-1:0] r_origin_x;
    logic signed [DATA_W-1:0] r_origin_y;
    logic signed [DATA_W-1:0] r_origin_z;
    logic [DATA_W-1:0]        r_inv_x;
    logic [DATA_W-1:0]        r_inv_y;
    logic [DATA_W-1:0]        r_inv_z;
    logic                     w_cfg_we;
    logic [2:0]               w_reg;

    t_qent w_fe_entry;
    logic  w_fe_push;
    logic  w_q_full;
    t_qent w_q_head;
    logic  w_q_empty;
    logic  w_q_pop;
    t_res  w_res;
    logic  w_res_push;
    logic  w_res_full;
    t_res  w_out;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;
    assign w_reg    = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_origin_z <= '0;
            r_inv_x    <= INV_RESET;
            r_inv_y    <= INV_RESET;
            r_inv_z    <= INV_RESET;
        end else if (w_cfg_we) begin
            case (w_reg)
                REG_ORIGIN_X: r_origin_x <= pwdata;
                REG_ORIGIN_Y: r_origin_y <= pwdata;
                REG_ORIGIN_Z: r_origin_z <= pwdata;
                REG_INV_X:    r_inv_x    <= pwdata;
                REG_INV_Y:    r_inv_y    <= pwdata;
                REG_INV_Z:    r_inv_z    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_ORIGIN_X: prdata = r_origin_x;
            REG_ORIGIN_Y: prdata = r_origin_y;
            REG_ORIGIN_Z: prdata = r_origin_z;
            REG_INV_X:    prdata = r_inv_x;
            REG_INV_Y:    prdata = r_inv_y;
            REG_INV_Z:    prdata = r_inv_z;
            default:      prdata = '0;
        endcase
    end

    tfs_front #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_operation      (i_operation),
        .i_sample_address (i_sample_address),
        .i_sample_data    (i_sample_data),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .i_point_z        (i_point_z),
        .i_origin_x       (r_origin_x),
        .i_origin_y       (r_origin_y),
        .i_origin_z       (r_origin_z),
        .i_inv_x          (r_inv_x),
        .i_inv_y          (r_inv_y),
        .i_inv_z          (r_inv_z),
        .o_entry          (w_fe_entry),
        .o_entry_push     (w_fe_push),
        .i_q_full         (w_q_full)
    );

    tfs_fifo #(
        .WIDTH ($bits(t_qent)),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fe_push),
        .i_data  (w_fe_entry),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_head),
        .o_empty (w_q_empty)
    );

    tfs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (w_q_head),
        .i_q_empty  (w_q_empty),
        .o_q_pop    (w_q_pop),
        .i_inv_x    (r_inv_x),
        .i_inv_y    (r_inv_y),
        .i_inv_z    (r_inv_z),
        .o_res      (w_res),
        .o_res_push (w_res_push),
        .i_res_full (w_res_full)
    );

    tfs_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_out),
        .o_empty (empty)
    );

    assign o_in_bounds   = w_out.inb;
    assign o_field_value = w_out.val;
    assign o_gradient_x  = w_out.gx;
    assign o_gradient_y  = w_out.gy;
    assign o_gradient_z  = w_out.gz;

endmodule
